@@ rtl/core/dmht_pkg.sv @@
// Shared types, constants and constant-table helpers for the direct-mapped
// key/value table core. No dependencies.

package dmht_pkg;

  localparam int unsigned SLOTS      = 101;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned KIND_W     = 2;

  localparam logic [KEY_W-1:0] EMPTY_KEY = 8'hFF;

  // djb2 over decimal digits of the key
  localparam int unsigned HASH_START = 5381;
  localparam int unsigned HASH_MULT  = 33;
  localparam int unsigned DIGIT_BASE = 10;
  localparam logic [IDX_W-1:0] HASH_SEED_MOD = IDX_W'(HASH_START % SLOTS);

  // q = (k * DIV10_MUL) >> DIV10_SHIFT is exact k / 10 for all 8-bit k
  localparam logic [KEY_W-1:0] DIV10_MUL   = 8'd205;
  localparam int unsigned      DIV10_SHIFT = 11;
  localparam int unsigned      QUOT_W      = 5;
  localparam int unsigned      DIGIT_W     = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] slot;
  } hash_res_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } tbl_wr_t;

  // Only called with elaboration-time constants to build lookup tables.
  function automatic logic [IDX_W-1:0] mul33_mod(input int unsigned h);
    return IDX_W'((h * HASH_MULT) % SLOTS);
  endfunction

  function automatic logic [IDX_W-1:0] digit_mod(input int unsigned d);
    return IDX_W'(d % SLOTS);
  endfunction

endpackage

@@ rtl/core/dmht_hash.sv @@
// Iterative slot-index unit: one decimal digit of the key per cycle,
// hash kept reduced modulo SLOTS. Depends on dmht_pkg.

module dmht_hash (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dmht_pkg::KEY_W-1:0]     key_i,
  output dmht_pkg::hash_res_t            res_o
);

  logic                           busy_q, busy_d;
  logic [dmht_pkg::KEY_W-1:0]     key_q, key_d;
  logic [dmht_pkg::IDX_W-1:0]     h_q, h_d;

  logic [dmht_pkg::IDX_W-1:0]     mul33_tab [dmht_pkg::SLOTS];
  logic [dmht_pkg::IDX_W-1:0]     dmod_tab  [2**dmht_pkg::DIGIT_W];

  logic [2*dmht_pkg::KEY_W-1:0]   prod;
  logic [dmht_pkg::QUOT_W-1:0]    quot;
  logic [dmht_pkg::KEY_W-1:0]     rem_full;
  logic [dmht_pkg::DIGIT_W-1:0]   digit;
  logic [dmht_pkg::IDX_W:0]       h_sum;
  logic [dmht_pkg::IDX_W-1:0]     h_next;

  for (genvar g = 0; g < dmht_pkg::SLOTS; g++) begin : g_mul33
    assign mul33_tab[g] = dmht_pkg::mul33_mod(g);
  end
  for (genvar g = 0; g < 2**dmht_pkg::DIGIT_W; g++) begin : g_dmod
    assign dmod_tab[g] = dmht_pkg::digit_mod(g);
  end

  // one digit step: peel off k % 10, fold into (h*33 + d) mod SLOTS
  always_comb begin
    prod     = key_q * dmht_pkg::DIV10_MUL;
    quot     = prod[dmht_pkg::DIV10_SHIFT +: dmht_pkg::QUOT_W];
    rem_full = key_q - dmht_pkg::KEY_W'(quot * dmht_pkg::KEY_W'(dmht_pkg::DIGIT_BASE));
    digit    = rem_full[dmht_pkg::DIGIT_W-1:0];
    h_sum    = {1'b0, mul33_tab[h_q]} + {1'b0, dmod_tab[digit]};
    if (h_sum >= (dmht_pkg::IDX_W+1)'(dmht_pkg::SLOTS)) begin
      h_next = dmht_pkg::IDX_W'(h_sum - (dmht_pkg::IDX_W+1)'(dmht_pkg::SLOTS));
    end else begin
      h_next = h_sum[dmht_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    key_d  = key_q;
    h_d    = h_q;
    if (start_i) begin
      busy_d = 1'b1;
      key_d  = key_i;
      h_d    = dmht_pkg::HASH_SEED_MOD;
    end else if (busy_q) begin
      if (key_q == '0) begin
        busy_d = 1'b0;
      end else begin
        key_d = dmht_pkg::KEY_W'(quot);
        h_d   = h_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    h_q   <= h_d;
  end

  assign res_o.done = busy_q && (key_q == '0);
  assign res_o.slot = h_q;

endmodule

@@ rtl/core/dmht_table.sv @@
// Slot storage: key and value memories with registered read, plus one
// written-flag per slot so unwritten slots read as empty. Depends on dmht_pkg.

module dmht_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dmht_pkg::tbl_wr_t            wr_i,
  input  logic                         rd_en_i,
  input  logic [dmht_pkg::IDX_W-1:0]   rd_addr_i,
  output logic [dmht_pkg::KEY_W-1:0]   rd_key_o,
  output logic [dmht_pkg::VAL_W-1:0]   rd_val_o
);

  logic [dmht_pkg::KEY_W-1:0] key_mem [dmht_pkg::SLOTS];
  logic [dmht_pkg::VAL_W-1:0] val_mem [dmht_pkg::SLOTS];
  logic [dmht_pkg::SLOTS-1:0] vld_q;
  logic                       rd_vld_q;
  logic [dmht_pkg::KEY_W-1:0] rd_key_q;
  logic [dmht_pkg::VAL_W-1:0] rd_val_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_mem[wr_i.addr] <= wr_i.key;
      val_mem[wr_i.addr] <= wr_i.val;
    end
    if (rd_en_i) begin
      rd_key_q <= key_mem[rd_addr_i];
      rd_val_q <= val_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_key_o = rd_vld_q ? rd_key_q : dmht_pkg::EMPTY_KEY;
  assign rd_val_o = rd_vld_q ? rd_val_q : '0;

endmodule

@@ rtl/core/direct_mapped_hash_key_value_table_core.sv @@
// Top level of the direct-mapped key/value table: stream ports, sequencer,
// entry count and result register. Depends on dmht_pkg, dmht_hash, dmht_table.

// One operation at a time. An insert, get or remove runs to completion before
// the next is accepted: the hash unit folds one decimal digit of the key per
// cycle (none for key 0), then the slot memory is read into a register and,
// in the execute state once the output register is free, compared and, for
// an insert or remove, written back. Results sit in an output register, so a
// new transaction is taken while the previous result waits. All slots read
// as empty with value zero straight after reset; no clearing pass is needed.

module direct_mapped_hash_key_value_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] key, [23:8] write_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] read_value, [31:16] entry_count
  output logic        m_axis_tuser    // [0] found
);

  dmht_pkg::state_e               state_q, state_d;
  dmht_pkg::kind_e                kind_q;
  logic [dmht_pkg::KEY_W-1:0]     key_q;
  logic [dmht_pkg::VAL_W-1:0]     wv_q;
  logic [dmht_pkg::CNT_W-1:0]     count_q, count_d;

  logic                           m_valid_q, m_valid_d;
  logic                           m_found_q, m_found_d;
  logic [dmht_pkg::VAL_W-1:0]     m_rv_q, m_rv_d;
  logic [dmht_pkg::CNT_W-1:0]     m_cnt_q, m_cnt_d;

  logic                           in_xfer;
  logic                           commit;
  logic                           hit;
  dmht_pkg::hash_res_t            hash_res;
  dmht_pkg::tbl_wr_t              tbl_wr;
  logic [dmht_pkg::KEY_W-1:0]     tbl_key;
  logic [dmht_pkg::VAL_W-1:0]     tbl_val;

  dmht_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .key_i   (s_axis_tdata[7:0]),
    .res_o   (hash_res)
  );

  dmht_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_en_i   (hash_res.done),
    .rd_addr_i (hash_res.slot),
    .rd_key_o  (tbl_key),
    .rd_val_o  (tbl_val)
  );

  assign s_axis_tready = (state_q == dmht_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == dmht_pkg::ST_EXEC) && (!m_valid_q || m_axis_tready);
  assign hit           = (tbl_key == key_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dmht_pkg::ST_IDLE: begin
        if (in_xfer) state_d = dmht_pkg::ST_HASH;
      end
      dmht_pkg::ST_HASH: begin
        if (hash_res.done) state_d = dmht_pkg::ST_EXEC;
      end
      dmht_pkg::ST_EXEC: begin
        if (commit) state_d = dmht_pkg::ST_IDLE;
      end
      default: state_d = dmht_pkg::ST_IDLE;
    endcase
  end

  // operation outputs: slot write-back, count, result
  always_comb begin
    tbl_wr.en   = 1'b0;
    tbl_wr.addr = hash_res.slot;
    tbl_wr.key  = key_q;
    tbl_wr.val  = wv_q;
    count_d     = count_q;
    m_found_d   = 1'b0;
    m_rv_d      = '0;
    if (commit) begin
      case (kind_q)
        dmht_pkg::KIND_INSERT: begin
          tbl_wr.en = 1'b1;
          if (!hit) count_d = count_q + 1'b1;
        end
        dmht_pkg::KIND_GET: begin
          m_found_d = hit;
          m_rv_d    = hit ? tbl_val : '0;
        end
        dmht_pkg::KIND_REMOVE: begin
          // empty mark, old value kept
          tbl_wr.en  = 1'b1;
          tbl_wr.key = dmht_pkg::EMPTY_KEY;
          tbl_wr.val = tbl_val;
          count_d    = count_q - 1'b1;
        end
        default: ;
      endcase
    end
    m_cnt_d = count_d;
    if (commit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dmht_pkg::ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= dmht_pkg::kind_e'(s_axis_tuser);
      key_q  <= s_axis_tdata[7:0];
      wv_q   <= s_axis_tdata[23:8];
    end
    if (commit) begin
      m_found_q <= m_found_d;
      m_rv_q    <= m_rv_d;
      m_cnt_q   <= m_cnt_d;
    end
  end

  // slot stays put in the hash unit until the next start, so it doubles as
  // the write address during EXEC
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = {m_cnt_q, m_rv_q};

  a_hash_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_res.done |-> state_q == dmht_pkg::ST_HASH)
    else $error("hash unit finished outside hash phase");

  a_accept_starts_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == dmht_pkg::ST_HASH)
    else $error("accepted transaction did not start hashing");

  a_count_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> count_q == $past(count_q))
    else $error("entry count changed without a committed operation");

  a_miss_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[15:0] == '0)
    else $error("nonzero read value without a hit");

  a_write_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.en |-> commit && state_q == dmht_pkg::ST_EXEC)
    else $error("slot write outside execute phase");

endmodule
